### sv/kmp_pkg.sv
package kmp_pkg;

   localparam int PRICE_W        = 32;
   localparam int GAIN_W         = 48;
   localparam int POS_W          = 50;
   localparam int TRADES_W       = 5;
   localparam int MAX_TRADES_DEF = 16;

   localparam logic [TRADES_W-1:0]     TRADES_RESET = TRADES_W'(1);
   localparam logic [GAIN_W-1:0]       GAIN_MAX     = '1;
   // most negative open position means nothing bought yet
   localparam logic signed [POS_W-1:0] NO_POSITION  = {1'b1, {(POS_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

endpackage

### sv/k_transaction_max_profit_top.sv
// a price transfer is taken, then the walk steps through the trade counts,
//   one count per cycle through the closed-gain and open-position memories
// a new price is taken only in idle, after the walk of the previous one is done
// a last price's profit is registered at walk end, or held until the output frees
// reset: synchronous; max_trades returns to 1, all memory entries read as cleared
module k_transaction_max_profit_top #(
   parameter int MaxTrades = kmp_pkg::MAX_TRADES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [kmp_pkg::PRICE_W-1:0]  req_tdata,   // [31:0] price
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [kmp_pkg::GAIN_W-1:0]   rsp_tdata,   // [47:0] profit
   input  logic                         csr_wr_en,
   input  logic [kmp_pkg::TRADES_W-1:0] csr_wr_data
);
   import kmp_pkg::*;

   localparam int IdxW = (MaxTrades > 1) ? $clog2(MaxTrades) : 1;
   localparam int KW   = (IdxW + 1 > TRADES_W) ? IdxW + 1 : TRADES_W;

   state_type state_ff, state_in;
   logic [IdxW-1:0] cur_ff, cur_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic last_ff, last_in;
   logic [GAIN_W-1:0] prev_ff, prev_in;
   logic [GAIN_W-1:0] res_ff, res_in;
   logic [MaxTrades-1:0] vld_ff, vld_in;
   logic [TRADES_W-1:0] csr_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [GAIN_W-1:0] rsp_data_ff, rsp_data_in;

   logic [GAIN_W-1:0] closed_mem [MaxTrades];
   logic signed [POS_W-1:0] open_mem [MaxTrades];
   logic [GAIN_W-1:0] closed_rd_ff;
   logic signed [POS_W-1:0] open_rd_ff;

   logic accept, rd_en, wr_en, at_end, hit, slot_free;
   logic [IdxW-1:0] rd_addr;
   logic [GAIN_W-1:0] closed_old, closed_new, sell_sat, fin_val;
   logic signed [POS_W-1:0] open_old, open_new, buy, sell;
   logic [KW-1:0] k_cfg, k_eff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign accept    = req_tvalid && req_tready;
   assign at_end    = (cur_ff == IdxW'(MaxTrades - 1));
   assign wr_en     = (state_ff == ST_RUN);
   assign rd_en     = accept || ((state_ff == ST_RUN) && !at_end);
   assign rd_addr   = accept ? '0 : cur_ff + IdxW'(1);
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // entries not touched since the last clear read as their reset value
   assign closed_old = vld_ff[cur_ff] ? closed_rd_ff : '0;
   assign open_old   = vld_ff[cur_ff] ? open_rd_ff : NO_POSITION;

   assign buy      = $signed(POS_W'(prev_ff)) - $signed(POS_W'(price_ff));
   assign open_new = (buy > open_old) ? buy : open_old;
   assign sell     = open_new + $signed(POS_W'(price_ff));

   always_comb begin
      if (sell < 0) begin
         sell_sat = '0;
      end else if (sell > $signed(POS_W'(GAIN_MAX))) begin
         sell_sat = GAIN_MAX;
      end else begin
         sell_sat = sell[GAIN_W-1:0];
      end
   end

   assign closed_new = (sell_sat > closed_old) ? sell_sat : closed_old;

   assign k_cfg   = KW'(csr_ff);
   assign k_eff   = (k_cfg > KW'(MaxTrades)) ? KW'(MaxTrades) : k_cfg;
   assign hit     = (k_eff != '0) && (KW'(cur_ff) == k_eff - KW'(1));
   assign fin_val = hit ? closed_new : res_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      price_in     = price_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;
      vld_in       = vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in   = '0;
               prev_in  = '0;
               res_in   = '0;
               price_in = req_tdata;
               last_in  = req_tlast;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cur_in         = cur_ff + IdxW'(1);
            prev_in        = closed_new;
            res_in         = fin_val;
            vld_in[cur_ff] = 1'b1;
            if (at_end) begin
               if (!last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  vld_in = '0;
                  if (slot_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = fin_val;
                     state_in     = ST_IDLE;
                  end else begin
                     state_in = ST_HOLD;
                  end
               end
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         csr_ff       <= TRADES_RESET;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      price_ff    <= price_in;
      last_ff     <= last_in;
      prev_ff     <= prev_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         closed_rd_ff <= closed_mem[rd_addr];
         open_rd_ff   <= open_mem[rd_addr];
      end
      if (wr_en) begin
         closed_mem[cur_ff] <= closed_new;
         open_mem[cur_ff]   <= open_new;
      end
   end

endmodule

### sv/kmp_checker.sv
module kmp_checker #(
   parameter int MaxTrades = kmp_pkg::MAX_TRADES_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tvalid,
   input logic                         req_tready,
   input logic                         req_tlast,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [kmp_pkg::GAIN_W-1:0]   rsp_tdata
);
   import kmp_pkg::*;

   logic req_xfer;
   assign req_xfer = req_tvalid && req_tready;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one price at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("price taken while a walk is running");

   // a price without last comes back ready after the full walk
   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_tlast |-> ##(MaxTrades + 1) req_tready)
      else $error("walk length wrong");

   // a last price with the output free yields its result after the walk
   a_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_tlast && !rsp_tvalid |-> ##(MaxTrades + 1) rsp_tvalid)
      else $error("missing result for last price");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind k_transaction_max_profit_top kmp_checker #(.MaxTrades(MaxTrades)) u_kmp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tlast   (req_tlast),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);
